FILE: hdl/psg_pkg.sv
// Shared types, register codes and lookup tables for the three-channel sound generator.
package psg_pkg;

    localparam int REG_COUNT      = 16;
    localparam int ENV_STEPS      = 32;
    localparam int LEVEL_W        = 10;
    localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;
    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;

    localparam logic [3:0] REG_A_FINE       = 4'd0;
    localparam logic [3:0] REG_A_COARSE     = 4'd1;
    localparam logic [3:0] REG_B_FINE       = 4'd2;
    localparam logic [3:0] REG_B_COARSE     = 4'd3;
    localparam logic [3:0] REG_C_FINE       = 4'd4;
    localparam logic [3:0] REG_C_COARSE     = 4'd5;
    localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
    localparam logic [3:0] REG_MIXER        = 4'd7;
    localparam logic [3:0] REG_AMP_A        = 4'd8;
    localparam logic [3:0] REG_AMP_B        = 4'd9;
    localparam logic [3:0] REG_AMP_C        = 4'd10;
    localparam logic [3:0] REG_ENV_FINE     = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE   = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;
    localparam logic [3:0] REG_PORT_A       = 4'd14;

    localparam logic CFG_TICK_STEP   = 1'b0;
    localparam logic CFG_LEVEL_BOOST = 1'b1;

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_TICK   = 2'd3
    } opcode_t;

    // Envelope controls handed from the register file to the envelope unit
    typedef struct packed {
        logic        tick;
        logic        restart_set;
        logic        enable;
        logic [15:0] period;
        logic [3:0]  shape;
    } env_ctrl_t;

    function automatic logic [7:0] reg_mask(input logic [3:0] idx);
        logic [7:0] m;
        case (idx)
            REG_A_COARSE, REG_B_COARSE, REG_C_COARSE, REG_ENV_SHAPE: m = 8'h0F;
            REG_NOISE_PERIOD, REG_AMP_A, REG_AMP_B, REG_AMP_C:       m = 8'h1F;
            default:                                                 m = 8'hFF;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] amp_base(input logic [3:0] v);
        logic [5:0] a;
        case (v)
            4'd0:    a = 6'd0;
            4'd1:    a = 6'd1;
            4'd2:    a = 6'd1;
            4'd3:    a = 6'd1;
            4'd4:    a = 6'd2;
            4'd5:    a = 6'd2;
            4'd6:    a = 6'd3;
            4'd7:    a = 6'd5;
            4'd8:    a = 6'd6;
            4'd9:    a = 6'd9;
            4'd10:   a = 6'd13;
            4'd11:   a = 6'd17;
            4'd12:   a = 6'd22;
            4'd13:   a = 6'd29;
            4'd14:   a = 6'd36;
            default: a = 6'd45;
        endcase
        return a;
    endfunction

    // Scaled amplitude; peak is 45 * 16 = 720, which fits the level width
    function automatic logic [LEVEL_W-1:0] amp_of(input logic [3:0] v, input logic [3:0] boost);
        logic [4:0]  scale;
        logic [10:0] prod;
        scale = {1'b0, boost} + 5'd1;
        prod  = {5'd0, amp_base(v)} * {6'd0, scale};
        return prod[LEVEL_W-1:0];
    endfunction

    // Volume of an envelope shape at one of its steps
    function automatic logic [3:0] env_value(input logic [3:0] shape, input logic [4:0] step);
        logic [3:0] up;
        logic [3:0] dn;
        logic [3:0] v;
        up = step[3:0];
        dn = ~step[3:0];
        if (!step[4]) begin
            v = shape[2] ? up : dn;
        end else begin
            case (shape)
                4'd8, 4'd14:  v = dn;
                4'd10, 4'd12: v = up;
                4'd11, 4'd13: v = 4'hF;
                default:      v = 4'h0;
            endcase
        end
        return v;
    endfunction

endpackage

FILE: hdl/psg_three_channel_tick.sv
// Top level of the three-channel sound generator with register port and tick input.
//
// Input channel (s_valid/s_ready): each transaction carries an opcode and a data byte:
// select a register, write the selected register (masked), read it, or tick.
// A tick advances the three tone dividers, the noise divider with its 32-bit LFSR
// and the envelope, then latches the three channel levels.
// Result channel (m_valid/m_ready): exactly one result per input transaction, holding
// the read byte (zero unless the opcode was a read) and the levels of the last tick.
// The result register loads at the accepting edge.
// Throughput is one transaction per cycle while results are taken; all work of an item
// is one pass of logic between the state registers and the result register.
// When the receiver stalls, the result register holds and s_ready drops until the
// result is taken; s_ready is high whenever the result register is empty or being read.
// Reset clears all state: registers to zero except R14 (0xFF), LFSR to its seed,
// tick step to 1 and level boost to 0. No clearing pass is needed.
// The user must write configuration (cfg_we/cfg_index/cfg_wdata) only while idle; the block does not enforce it.
module psg_three_channel_tick (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [9:0]  m_level_a,
    output logic [8:0]  m_level_b,
    output logic [9:0]  m_level_c,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    localparam int LW = psg_pkg::LEVEL_W;

    logic [7:0]  tick_step_reg;
    logic [3:0]  level_boost_reg;

    logic [7:0]  regfile_reg [psg_pkg::REG_COUNT];
    logic [7:0]  regfile_next [psg_pkg::REG_COUNT];
    logic [7:0]  sel_reg, sel_next;
    logic [15:0] tone_cnt_reg [3];
    logic [15:0] tone_cnt_next [3];
    logic [2:0]  tone_bit_reg, tone_bit_next;
    logic [15:0] noise_cnt_reg, noise_cnt_next;
    logic        noise_out_reg, noise_out_next;
    logic [31:0] lfsr_reg, lfsr_next;

    logic        m_valid_reg;
    logic [7:0]  m_read_data_reg, m_read_data_next;
    logic [LW-1:0] m_level_a_reg, m_level_a_next;
    logic [LW-2:0] m_level_b_reg, m_level_b_next;
    logic [LW-1:0] m_level_c_reg, m_level_c_next;

    logic        accept;
    logic        is_tick;
    logic        sel_ok;
    logic [7:0]  r7;
    logic [2:0]  outb;
    logic [16:0] tone_sum;
    logic [15:0] tone_sat;
    logic [15:0] period;
    logic        noise_on;
    logic [16:0] noise_sum;
    logic [15:0] noise_sat;
    logic [31:0] lfsr_step;
    logic        noise_eff;
    logic [7:0]  vol;
    logic [LW-1:0] lvl [3];
    logic [LW-1:0] env_level;

    psg_pkg::env_ctrl_t env_ctrl;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_tick = (s_opcode == psg_pkg::OP_TICK);
    assign sel_ok  = (sel_reg[7:4] == 4'd0);
    assign r7      = regfile_reg[psg_pkg::REG_MIXER];

    always_comb begin
        env_ctrl.tick        = accept && is_tick;
        env_ctrl.restart_set = accept && (s_opcode == psg_pkg::OP_WRITE) && sel_ok
                               && (sel_reg[3:0] == psg_pkg::REG_ENV_SHAPE);
        env_ctrl.enable      = regfile_reg[psg_pkg::REG_AMP_A][4]
                               || regfile_reg[psg_pkg::REG_AMP_B][4]
                               || regfile_reg[psg_pkg::REG_AMP_C][4];
        env_ctrl.period      = {regfile_reg[psg_pkg::REG_ENV_COARSE],
                                regfile_reg[psg_pkg::REG_ENV_FINE]};
        env_ctrl.shape       = regfile_reg[psg_pkg::REG_ENV_SHAPE][3:0];
    end

    psg_env u_env (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (env_ctrl),
        .tick_step   (tick_step_reg),
        .level_boost (level_boost_reg),
        .env_level   (env_level)
    );

    always_comb begin
        regfile_next     = regfile_reg;
        sel_next         = sel_reg;
        tone_cnt_next    = tone_cnt_reg;
        tone_bit_next    = tone_bit_reg;
        noise_cnt_next   = noise_cnt_reg;
        noise_out_next   = noise_out_reg;
        lfsr_next        = lfsr_reg;
        m_read_data_next = 8'd0;
        m_level_a_next   = m_level_a_reg;
        m_level_b_next   = m_level_b_reg;
        m_level_c_next   = m_level_c_reg;
        outb             = tone_bit_reg;
        tone_sum         = '0;
        tone_sat         = '0;
        period           = '0;
        vol              = '0;

        // Tone dividers; output bit is the value before this tick's toggle
        for (int ch = 0; ch < 3; ch++) begin
            period   = {regfile_reg[psg_pkg::REG_A_COARSE + 4'(2*ch)],
                        regfile_reg[psg_pkg::REG_A_FINE + 4'(2*ch)]};
            tone_sum = {1'b0, tone_cnt_reg[ch]} + {9'd0, tick_step_reg};
            tone_sat = tone_sum[16] ? 16'hFFFF : tone_sum[15:0];
            if (!r7[ch]) begin
                if (tone_sat >= period && period >= {8'd0, tick_step_reg}) begin
                    tone_bit_next[ch] = !tone_bit_reg[ch];
                    tone_cnt_next[ch] = 16'd0;
                end else begin
                    tone_cnt_next[ch] = tone_sat;
                end
            end else begin
                outb[ch]          = 1'b1;
                tone_cnt_next[ch] = 16'd0;
            end
        end

        noise_on  = !(&r7[5:3]);
        noise_sum = {1'b0, noise_cnt_reg} + {9'd0, tick_step_reg};
        noise_sat = noise_sum[16] ? 16'hFFFF : noise_sum[15:0];
        lfsr_step = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? psg_pkg::LFSR_TAPS : 32'd0);
        noise_eff = noise_out_reg;
        if (noise_on) begin
            if (noise_sat >= {7'd0, regfile_reg[psg_pkg::REG_NOISE_PERIOD], 1'b0}) begin
                lfsr_next      = lfsr_step;
                noise_eff      = lfsr_step[31];
                noise_cnt_next = 16'd0;
            end else begin
                noise_cnt_next = noise_sat;
            end
            noise_out_next = noise_eff;
            for (int ch = 0; ch < 3; ch++) begin
                if (!noise_eff && !r7[3+ch]) begin
                    outb[ch] = 1'b0;
                end
            end
        end

        for (int ch = 0; ch < 3; ch++) begin
            vol = regfile_reg[psg_pkg::REG_AMP_A + 4'(ch)];
            if (!outb[ch]) begin
                lvl[ch] = '0;
            end else if (vol[4]) begin
                lvl[ch] = env_level;
            end else begin
                lvl[ch] = psg_pkg::amp_of(vol[3:0], level_boost_reg);
            end
        end

        case (s_opcode)
            psg_pkg::OP_SELECT: begin
                sel_next = s_data_byte;
            end
            psg_pkg::OP_WRITE: begin
                if (sel_ok) begin
                    regfile_next[sel_reg[3:0]] = s_data_byte & psg_pkg::reg_mask(sel_reg[3:0]);
                    if (sel_reg[3:0] == psg_pkg::REG_NOISE_PERIOD) begin
                        noise_cnt_next = 16'd0;
                    end
                end
                tone_cnt_next  = tone_cnt_reg;
                tone_bit_next  = tone_bit_reg;
                noise_out_next = noise_out_reg;
                lfsr_next      = lfsr_reg;
                if (!(sel_ok && sel_reg[3:0] == psg_pkg::REG_NOISE_PERIOD)) begin
                    noise_cnt_next = noise_cnt_reg;
                end
            end
            psg_pkg::OP_READ: begin
                if (sel_ok) begin
                    m_read_data_next = regfile_reg[sel_reg[3:0]];
                end
            end
            default: begin
                m_level_a_next = lvl[0];
                m_level_b_next = lvl[1][LW-1:1];
                m_level_c_next = lvl[2];
            end
        endcase

        // Only a tick moves the dividers and LFSR
        if (s_opcode == psg_pkg::OP_SELECT || s_opcode == psg_pkg::OP_READ) begin
            tone_cnt_next  = tone_cnt_reg;
            tone_bit_next  = tone_bit_reg;
            noise_cnt_next = noise_cnt_reg;
            noise_out_next = noise_out_reg;
            lfsr_next      = lfsr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_step_reg   <= 8'd1;
            level_boost_reg <= 4'd0;
        end else if (cfg_we) begin
            if (cfg_index == psg_pkg::CFG_TICK_STEP) begin
                tick_step_reg <= cfg_wdata;
            end else begin
                level_boost_reg <= cfg_wdata[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < psg_pkg::REG_COUNT; i++) begin
                regfile_reg[i] <= (4'(i) == psg_pkg::REG_PORT_A) ? 8'hFF : 8'h00;
            end
            sel_reg       <= '0;
            tone_cnt_reg  <= '{default: 16'd0};
            tone_bit_reg  <= '0;
            noise_cnt_reg <= '0;
            noise_out_reg <= 1'b0;
            lfsr_reg      <= psg_pkg::LFSR_SEED;
            m_valid_reg   <= 1'b0;
            m_read_data_reg <= '0;
            m_level_a_reg <= '0;
            m_level_b_reg <= '0;
            m_level_c_reg <= '0;
        end else begin
            if (accept) begin
                regfile_reg     <= regfile_next;
                sel_reg         <= sel_next;
                tone_cnt_reg    <= tone_cnt_next;
                tone_bit_reg    <= tone_bit_next;
                noise_cnt_reg   <= noise_cnt_next;
                noise_out_reg   <= noise_out_next;
                lfsr_reg        <= lfsr_next;
                m_valid_reg     <= 1'b1;
                m_read_data_reg <= m_read_data_next;
                m_level_a_reg   <= m_level_a_next;
                m_level_b_reg   <= m_level_b_next;
                m_level_c_reg   <= m_level_c_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_level_a   = m_level_a_reg;
    assign m_level_b   = m_level_b_reg;
    assign m_level_c   = m_level_c_reg;

    a_accept_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction did not produce a result");

    a_read_data_only_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_opcode != psg_pkg::OP_READ) |=> (m_read_data == 8'd0))
        else $error("nonzero read data for a non-read opcode");

    a_level_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_level_a <= 10'd720) && (m_level_c <= 10'd720) && (m_level_b <= 9'd360))
        else $error("channel level beyond the amplitude table range");

endmodule

FILE: hdl/psg_env.sv
// Envelope generator: period counter, step position, restart flag and current level.
module psg_env (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psg_pkg::env_ctrl_t            ctrl,
    input  logic [7:0]                    tick_step,
    input  logic [3:0]                    level_boost,
    output logic [psg_pkg::LEVEL_W-1:0]   env_level
);

    logic [31:0]                  cnt_reg, cnt_next;
    logic [5:0]                   pos_reg, pos_next;
    logic                         restart_reg, restart_next;
    logic [psg_pkg::LEVEL_W-1:0]  level_reg, level_next;

    logic        active;
    logic [32:0] sum;
    logic [31:0] cnt_sat;
    logic [31:0] cnt_eff;
    logic [5:0]  pos_eff;
    logic [5:0]  pos_wrap;
    logic [31:0] period2;
    logic [32:0] diff;

    always_comb begin
        active  = ctrl.tick && ctrl.enable;
        sum     = {1'b0, cnt_reg} + {25'd0, tick_step};
        cnt_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        cnt_eff = restart_reg ? 32'd0 : cnt_sat;
        pos_eff = restart_reg ? 6'd0 : pos_reg;
        period2 = {15'd0, ctrl.period, 1'b0};
        diff    = {1'b0, cnt_eff} - {1'b0, period2};

        // Past the last step: loop for shapes with continue set and hold clear, else hold
        if (pos_eff >= 6'(psg_pkg::ENV_STEPS)) begin
            pos_wrap = (ctrl.shape[3] && !ctrl.shape[0]) ? 6'd0 : 6'(psg_pkg::ENV_STEPS - 1);
        end else begin
            pos_wrap = pos_eff;
        end

        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        restart_next = restart_reg || ctrl.restart_set;
        level_next   = level_reg;
        if (active) begin
            restart_next = 1'b0;
            if (!diff[32]) begin
                cnt_next   = diff[31:0];
                pos_next   = pos_wrap + 6'd1;
                level_next = psg_pkg::amp_of(psg_pkg::env_value(ctrl.shape, pos_wrap[4:0]),
                                             level_boost);
            end else begin
                cnt_next = cnt_eff;
                pos_next = pos_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            pos_reg     <= '0;
            restart_reg <= 1'b0;
            level_reg   <= '0;
        end else begin
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            restart_reg <= restart_next;
            level_reg   <= level_next;
        end
    end

    assign env_level = level_next;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the three-channel sound generator: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 6;
    localparam int TIMEOUT_CYCLES  = 400000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 212;
    localparam int LONG_HOLD       = 80;
    localparam int MAX_REPORTS     = 10;

    localparam logic [7:0] WRITE_MASK [16] = '{
        8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'h1F, 8'hFF,
        8'h1F, 8'h1F, 8'h1F, 8'hFF, 8'hFF, 8'h0F, 8'hFF, 8'hFF
    };
    localparam logic [5:0] AMP_TABLE [16] = '{
        6'd0, 6'd1, 6'd1, 6'd1, 6'd2, 6'd2, 6'd3, 6'd5,
        6'd6, 6'd9, 6'd13, 6'd17, 6'd22, 6'd29, 6'd36, 6'd45
    };

    // tick step and level boost per phase; phase 0 runs on reset values
    localparam logic [7:0] STEP_SET  [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd1, 8'd128, 8'd17, 8'd2};
    localparam logic [3:0] BOOST_SET [PHASES] = '{4'd0, 4'd15, 4'd7, 4'd15, 4'd0, 4'd1, 4'd0, 4'd9};

    typedef struct packed {
        logic [7:0] read_byte;
        logic [9:0] lvl_a;
        logic [8:0] lvl_b;
        logic [9:0] lvl_c;
    } psg_out_t;

    typedef struct packed {
        psg_pkg::opcode_t op;
        logic [7:0]       data;
        logic             known;
        psg_out_t         want;
    } step_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam psg_out_t QUIET = '{8'h00, 10'd0, 9'd0, 10'd0};

    // typed expectations only where obvious: reset contents, out-of-range index, masking, a fixed-level tick
    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{psg_pkg::OP_READ,   8'h00, 1'b1, QUIET},
        '{psg_pkg::OP_SELECT, {4'd0, psg_pkg::REG_PORT_A}, 1'b1, QUIET},
        '{psg_pkg::OP_READ,   8'h00, 1'b1, '{8'hFF, 10'd0, 9'd0, 10'd0}},
        '{psg_pkg::OP_SELECT, 8'hFF, 1'b1, QUIET},
        '{psg_pkg::OP_WRITE,  8'hAB, 1'b1, QUIET},
        '{psg_pkg::OP_READ,   8'h00, 1'b1, QUIET},
        '{psg_pkg::OP_SELECT, 8'h10, 1'b1, QUIET},
        '{psg_pkg::OP_READ,   8'hFF, 1'b1, QUIET},
        '{psg_pkg::OP_SELECT, {4'd0, psg_pkg::REG_A_COARSE}, 1'b1, QUIET},
        '{psg_pkg::OP_WRITE,  8'hFF, 1'b1, QUIET},
        '{psg_pkg::OP_READ,   8'h00, 1'b1, '{8'h0F, 10'd0, 9'd0, 10'd0}},
        '{psg_pkg::OP_TICK,   8'h00, 1'b0, QUIET},
        '{psg_pkg::OP_SELECT, {4'd0, psg_pkg::REG_MIXER}, 1'b0, QUIET},
        '{psg_pkg::OP_WRITE,  8'h3F, 1'b0, QUIET},
        '{psg_pkg::OP_SELECT, {4'd0, psg_pkg::REG_AMP_A}, 1'b0, QUIET},
        '{psg_pkg::OP_WRITE,  8'hEF, 1'b0, QUIET},
        '{psg_pkg::OP_TICK,   8'hFF, 1'b1, '{8'h00, 10'd45, 9'd0, 10'd0}},
        '{psg_pkg::OP_SELECT, {4'd0, psg_pkg::REG_AMP_B}, 1'b0, QUIET},
        '{psg_pkg::OP_WRITE,  8'hFF, 1'b0, QUIET},
        '{psg_pkg::OP_SELECT, {4'd0, psg_pkg::REG_ENV_SHAPE}, 1'b0, QUIET},
        '{psg_pkg::OP_WRITE,  8'h0B, 1'b0, QUIET},
        '{psg_pkg::OP_TICK,   8'h00, 1'b0, QUIET},
        '{psg_pkg::OP_SELECT, {4'd0, psg_pkg::REG_NOISE_PERIOD}, 1'b0, QUIET},
        '{psg_pkg::OP_WRITE,  8'h00, 1'b0, QUIET},
        '{psg_pkg::OP_TICK,   8'h00, 1'b0, QUIET}
    };

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    psg_pkg::opcode_t s_opcode = psg_pkg::OP_SELECT;
    logic [7:0]       s_data_byte = 8'h00;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [7:0]       m_read_data;
    logic [9:0]       m_level_a;
    logic [8:0]       m_level_b;
    logic [9:0]       m_level_c;
    logic             cfg_we = 1'b0;
    logic             cfg_index = 1'b0;
    logic [7:0]       cfg_wdata = 8'h00;

    // chip image kept by the testbench
    logic [7:0]  regs [16];
    logic [7:0]  sel_index;
    logic [15:0] tone_cnt [3];
    logic        tone_bit [3];
    logic [15:0] noise_cnt;
    logic        noise_out;
    logic [31:0] lfsr;
    logic [31:0] env_cnt;
    logic [5:0]  env_pos;
    logic        env_restart;
    logic [9:0]  env_level;
    logic [9:0]  held_lvl [3];
    logic [7:0]  step_cfg;
    logic [3:0]  boost_cfg;

    psg_out_t outputs_due [$];

    int   mismatches = 0;
    int   items_sent = 0;
    int   ticks_sent = 0;
    int   reads_sent = 0;
    int   hold_requests = 0;
    int   holds_done = 0;
    logic idling_on = 1'b1;
    logic [7:0] gen_sel = 8'h00;

    psg_three_channel_tick u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_level_a   (m_level_a),
        .m_level_b   (m_level_b),
        .m_level_c   (m_level_c),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic void chip_reset();
        for (int i = 0; i < 16; i++) regs[i] = 8'h00;
        regs[psg_pkg::REG_PORT_A] = 8'hFF;
        sel_index   = 8'h00;
        for (int ch = 0; ch < 3; ch++) begin
            tone_cnt[ch] = 16'h0000;
            tone_bit[ch] = 1'b0;
            held_lvl[ch] = 10'd0;
        end
        noise_cnt   = 16'h0000;
        noise_out   = 1'b0;
        lfsr        = psg_pkg::LFSR_SEED;
        env_cnt     = 32'h0;
        env_pos     = 6'd0;
        env_restart = 1'b0;
        env_level   = 10'd0;
        step_cfg    = 8'd1;
        boost_cfg   = 4'd0;
    endfunction

    function automatic logic [9:0] scaled_amp(logic [3:0] vol);
        return 10'(AMP_TABLE[vol]) * (10'(boost_cfg) + 10'd1);
    endfunction

    // first 16 steps ramp by shape bit 2; the second half depends on the whole shape
    function automatic logic [3:0] env_volume(logic [3:0] shape, logic [4:0] pos);
        logic [3:0] rise;
        logic [3:0] fall;
        logic [3:0] vol;
        rise = pos[3:0];
        fall = 4'd15 - pos[3:0];
        if (!pos[4]) begin
            vol = shape[2] ? rise : fall;
        end else begin
            case (shape)
                4'd8, 4'd14:  vol = fall;
                4'd10, 4'd12: vol = rise;
                4'd11, 4'd13: vol = 4'd15;
                default:      vol = 4'd0;
            endcase
        end
        return vol;
    endfunction

    function automatic void chip_tick();
        logic [7:0]  mixer;
        logic [31:0] inc;
        logic [31:0] sum;
        logic [32:0] wide;
        logic [31:0] env_period;
        logic [15:0] period;
        logic [2:0]  out_on;
        logic [3:0]  shape;
        logic [7:0]  vol_reg;
        logic [9:0]  lvl;
        mixer = regs[psg_pkg::REG_MIXER];
        inc   = {24'd0, step_cfg};
        for (int ch = 0; ch < 3; ch++) begin
            period     = {regs[psg_pkg::REG_A_FINE + 2 * ch + 1],
                          regs[psg_pkg::REG_A_FINE + 2 * ch]};
            out_on[ch] = tone_bit[ch];
            if (!mixer[ch]) begin
                sum = {16'd0, tone_cnt[ch]} + inc;
                if (sum > 32'hFFFF) sum = 32'hFFFF;
                if (sum >= {16'd0, period} && {16'd0, period} >= inc) begin
                    tone_bit[ch] = ~tone_bit[ch];
                    sum = 32'd0;
                end
                tone_cnt[ch] = sum[15:0];
            end else begin
                out_on[ch]   = 1'b1;
                tone_cnt[ch] = 16'h0000;
            end
        end
        if ((~mixer & 8'h38) != 8'h00) begin
            sum = {16'd0, noise_cnt} + inc;
            if (sum > 32'hFFFF) sum = 32'hFFFF;
            if (sum >= {23'd0, regs[psg_pkg::REG_NOISE_PERIOD], 1'b0}) begin
                lfsr      = (lfsr >> 1) ^ (lfsr[0] ? psg_pkg::LFSR_TAPS : 32'h0);
                noise_out = lfsr[31];
                sum       = 32'd0;
            end
            noise_cnt = sum[15:0];
            if (!noise_out) begin
                for (int ch = 0; ch < 3; ch++)
                    if (!mixer[3 + ch]) out_on[ch] = 1'b0;
            end
        end
        if (((regs[psg_pkg::REG_AMP_A] | regs[psg_pkg::REG_AMP_B] | regs[psg_pkg::REG_AMP_C])
             & 8'h10) != 8'h00) begin
            env_period = {15'd0, regs[psg_pkg::REG_ENV_COARSE], regs[psg_pkg::REG_ENV_FINE],
                          1'b0};
            wide       = {1'b0, env_cnt} + {1'b0, inc};
            env_cnt    = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
            if (env_restart) begin
                env_pos     = 6'd0;
                env_cnt     = 32'h0;
                env_restart = 1'b0;
            end
            if (env_cnt >= env_period) begin
                shape   = regs[psg_pkg::REG_ENV_SHAPE][3:0];
                env_cnt = env_cnt - env_period;
                // loop on continue-without-hold shapes, otherwise park on the last step
                if (env_pos >= psg_pkg::ENV_STEPS)
                    env_pos = (shape[3] && !shape[0]) ? 6'd0 : 6'(psg_pkg::ENV_STEPS - 1);
                env_level = scaled_amp(env_volume(shape, env_pos[4:0]));
                env_pos   = env_pos + 6'd1;
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            vol_reg = regs[psg_pkg::REG_AMP_A + ch];
            lvl     = 10'd0;
            if (out_on[ch]) lvl = vol_reg[4] ? env_level : scaled_amp(vol_reg[3:0]);
            if (ch == 1) lvl = lvl >> 1;
            held_lvl[ch] = lvl;
        end
    endfunction

    function automatic psg_out_t chip_apply(psg_pkg::opcode_t op, logic [7:0] data);
        psg_out_t res;
        res.read_byte = 8'h00;
        case (op)
            psg_pkg::OP_SELECT: sel_index = data;
            psg_pkg::OP_WRITE: begin
                if (sel_index < psg_pkg::REG_COUNT) begin
                    regs[sel_index[3:0]] = data & WRITE_MASK[sel_index[3:0]];
                    if (sel_index == psg_pkg::REG_NOISE_PERIOD) noise_cnt = 16'h0000;
                    else if (sel_index == psg_pkg::REG_ENV_SHAPE) env_restart = 1'b1;
                end
            end
            psg_pkg::OP_READ: begin
                if (sel_index < psg_pkg::REG_COUNT) res.read_byte = regs[sel_index[3:0]];
            end
            default: chip_tick();
        endcase
        res.lvl_a = held_lvl[0];
        res.lvl_b = held_lvl[1][8:0];
        res.lvl_c = held_lvl[2];
        return res;
    endfunction

    task automatic flag_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        psg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outputs_due.size() == 0) begin
                flag_mismatch("result with nothing pending, read_data", 0, m_read_data);
            end else begin
                want = outputs_due.pop_front();
                if (m_read_data !== want.read_byte) flag_mismatch("read_data", want.read_byte, m_read_data);
                if (m_level_a !== want.lvl_a) flag_mismatch("level_a", want.lvl_a, m_level_a);
                if (m_level_b !== want.lvl_b) flag_mismatch("level_b", want.lvl_b, m_level_b);
                if (m_level_c !== want.lvl_c) flag_mismatch("level_c", want.lvl_c, m_level_c);
            end
        end
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(negedge aclk);
            if (holds_done != hold_requests) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                holds_done++;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(psg_pkg::opcode_t op, logic [7:0] data, logic known, psg_out_t typed);
        psg_out_t got;
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_data_byte <= data;
        do @(posedge aclk); while (!s_ready);
        got = chip_apply(op, data);
        outputs_due.push_back(known ? typed : got);
        items_sent++;
        if (op == psg_pkg::OP_TICK) ticks_sent++;
        if (op == psg_pkg::OP_READ) reads_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_config(logic idx, logic [7:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == psg_pkg::CFG_TICK_STEP) step_cfg = value;
        else boost_cfg = value[3:0];
    endtask

    // mostly register traffic that shapes the sound; periods kept short so counters wrap often
    task automatic random_item();
        int               pick;
        psg_pkg::opcode_t op;
        logic [7:0]       value;
        pick  = $urandom_range(0, 99);
        value = 8'($urandom);
        if (pick < 35) begin
            op = psg_pkg::OP_TICK;
        end else if (pick < 55) begin
            op = psg_pkg::OP_SELECT;
            if ($urandom_range(0, 9) != 0) value = 8'($urandom_range(0, psg_pkg::REG_COUNT - 1));
            gen_sel = value;
        end else if (pick < 85) begin
            op = psg_pkg::OP_WRITE;
            case (gen_sel)
                psg_pkg::REG_A_FINE, psg_pkg::REG_B_FINE, psg_pkg::REG_C_FINE:
                    if ($urandom_range(0, 3) != 0) value = 8'($urandom_range(0, 20));
                psg_pkg::REG_A_COARSE, psg_pkg::REG_B_COARSE, psg_pkg::REG_C_COARSE,
                psg_pkg::REG_ENV_COARSE:
                    if ($urandom_range(0, 5) != 0) value = 8'h00;
                psg_pkg::REG_NOISE_PERIOD:
                    if ($urandom_range(0, 3) != 0) value = 8'($urandom_range(0, 6));
                psg_pkg::REG_ENV_FINE:
                    if ($urandom_range(0, 3) != 0) value = 8'($urandom_range(0, 3));
                default: ;
            endcase
        end else begin
            op = psg_pkg::OP_READ;
        end
        send_item(op, value, 1'b0, QUIET);
    endtask

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        chip_reset();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(DIRECTED[r].op, DIRECTED[r].data, DIRECTED[r].known, DIRECTED[r].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain_results();
                set_config(psg_pkg::CFG_TICK_STEP, STEP_SET[phase]);
                set_config(psg_pkg::CFG_LEVEL_BOOST,
                           {4'($urandom_range(0, 15)), BOOST_SET[phase]});
            end
            idling_on = (phase != PHASES - 1);
            if (phase == 1) hold_requests++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // pause the sender once until everything is back
                if (phase == 2 && n == ITEMS_PER_PHASE / 2) drain_results();
                random_item();
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        $display("Covered %0d transactions (%0d ticks, %0d reads) over %0d step/boost settings,",
                 items_sent, ticks_sent, reads_sent, PHASES);
        $display("including a long result-side stall and a full drain mid-stream.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
